FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check a condition on every cycle that shows a result word.
`define RQ_ASSERT_RSP(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      rsp_strobe |-> (cond)) else $error(msg);

`endif

FILE: hw/rtl/rq2nv_pkg.sv
// Shared constants, register indexes and word types of the RAW10 quad to NV12 unit.
package rq2nv_pkg;

   localparam int GAMMA_ENTRIES = 1024;
   localparam int SAMPLE_W      = 10;
   localparam int GAIN_W        = 12;
   localparam int DIM_W         = 13;
   localparam int COORD_W       = 12;
   localparam int CROW_W        = 11;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 13;
   localparam int LANES         = 4;

   // lanes of one quad
   localparam int LANE_RED   = 0;
   localparam int LANE_GTOP  = 1;
   localparam int LANE_GBOT  = 2;
   localparam int LANE_BLUE  = 3;

   localparam logic [7:0] LUMA_MIN   = 8'd16;
   localparam logic [7:0] LUMA_MAX   = 8'd235;
   localparam logic [7:0] CHROMA_MIN = 8'd16;
   localparam logic [7:0] CHROMA_MAX = 8'd240;

   localparam logic [SAMPLE_W-1:0] BLACK_LEVEL_RESET  = 10'd64;
   localparam logic [GAIN_W-1:0]   RED_GAIN_RESET     = 12'd410;
   localparam logic [GAIN_W-1:0]   GREEN_GAIN_RESET   = 12'd256;
   localparam logic [GAIN_W-1:0]   BLUE_GAIN_RESET    = 12'd390;
   localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RESET  = 13'd1640;
   localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RESET = 13'd1232;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLACK_LEVEL  = 3'd0,
      CSR_RED_GAIN     = 3'd1,
      CSR_GREEN_GAIN   = 3'd2,
      CSR_BLUE_GAIN    = 3'd3,
      CSR_IMAGE_WIDTH  = 3'd4,
      CSR_IMAGE_HEIGHT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [39:0]        upper_group;
      logic [39:0]        lower_group;
      logic               pair_select;
      logic [COORD_W-1:0] quad_col;
      logic [COORD_W-1:0] quad_row;
   } req_word_type;

   typedef struct packed {
      logic [COORD_W-1:0] dest_col;
      logic [COORD_W-1:0] dest_row;
      logic [CROW_W-1:0]  chroma_row;
      logic [7:0]         luma_red;
      logic [7:0]         luma_green_top;
      logic [7:0]         luma_green_bottom;
      logic [7:0]         luma_blue;
      logic [7:0]         chroma_blue;
      logic [7:0]         chroma_red;
   } rsp_word_type;

endpackage

FILE: hw/rtl/rq2nv_gamma_rom.sv
// Gamma ROM with two registered read ports, contents computed at elaboration.
module rq2nv_gamma_rom #(
   parameter int ENTRIES = rq2nv_pkg::GAMMA_ENTRIES
) (
   input  logic                       clock,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr [2],
   output logic [7:0]                 rd_data [2]
);
   import rq2nv_pkg::*;

   // entry i = round(255 * (i/top)^(1/2.2)), found as the count of k in 0..254
   // with i^5 * 510^11 >= (2k+1)^11 * top^5
   function automatic logic [7:0] gamma_entry(input int unsigned idx);
      logic [159:0] lhs;
      logic [159:0] rhs;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      lo = 0;
      hi = 255;
      for (int s = 0; s < 8; s++) begin
         if (lo < hi) begin
            mid = (lo + hi) >> 1;
            lhs = 160'd1;
            rhs = 160'd1;
            for (int n = 0; n < 11; n++) begin
               lhs = lhs * 160'd510;
               rhs = rhs * 160'(2 * mid + 1);
            end
            for (int n = 0; n < 5; n++) begin
               lhs = lhs * 160'(idx);
               rhs = rhs * 160'(ENTRIES - 1);
            end
            if (lhs >= rhs) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
      end
      return lo[7:0];
   endfunction

   logic [7:0] rom_table [ENTRIES];
   logic [7:0] rd_data_ff [2];

   for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
      localparam logic [7:0] Value = gamma_entry(g);
      assign rom_table[g] = Value;
   end

   always_ff @(posedge clock) begin
      rd_data_ff[0] <= rom_table[rd_addr[0]];
      rd_data_ff[1] <= rom_table[rd_addr[1]];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/raw10_quad_to_nv12_unit.sv
// Top level of the RAW10 RGGB quad to NV12 sample converter.
// One quad word is taken per clock cycle: start with busy low accepts it, and busy
// never rises, so quads may follow each other in every cycle. The result word is
// driven on rsp_word, marked by rsp_strobe for one cycle, and is taken at the clock
// edge that closes that cycle. The five register stages are: unpack and
// black-level subtract; white-balance multiply and saturate; gamma ROM read (the
// ROM's registered read port sets this stage); green mean and luma clamp; chroma
// weights and clamp into the output register. The receiver cannot stall the pipe,
// so every accepted quad gives exactly one result word. The gamma ROM is a constant
// table and needs no fill or clear after reset.
// Write the csr_ registers only while no quad is in flight; the unpack and gain
// stages read them live.
module raw10_quad_to_nv12_unit #(
   parameter int GAMMA_ENTRIES = rq2nv_pkg::GAMMA_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rq2nv_pkg::req_word_type             req_word,
   output logic                                rsp_strobe,
   output rq2nv_pkg::rsp_word_type             rsp_word,
   input  logic                                csr_we,
   input  logic [rq2nv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rq2nv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rq2nv_pkg::*;

   localparam int AddrW = $clog2(GAMMA_ENTRIES);
   localparam int ProdW = SAMPLE_W + GAIN_W;

   // pixel p of a packed group: high byte p, two low bits from byte 4
   function automatic logic [SAMPLE_W-1:0] unpack(input logic [39:0] grp,
                                                   input logic [1:0]  p);
      return {grp[8*p +: 8], grp[32 + 2*p +: 2]};
   endfunction

   function automatic logic [7:0] clamp_luma(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (v < LUMA_MIN) r = LUMA_MIN;
      if (v > LUMA_MAX) r = LUMA_MAX;
      return r;
   endfunction

   // floor(diff / 256) + 128, clamped to the chroma range
   function automatic logic [7:0] chroma_byte(input logic signed [16:0] diff);
      logic signed [9:0] c;
      logic [7:0]        r;
      c = 10'(diff >>> 8) + 10'sd128;
      if (c < $signed({2'b00, CHROMA_MIN})) begin
         r = CHROMA_MIN;
      end else if (c > $signed({2'b00, CHROMA_MAX})) begin
         r = CHROMA_MAX;
      end else begin
         r = c[7:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [SAMPLE_W-1:0] black_level_ff;
   logic [GAIN_W-1:0]   red_gain_ff;
   logic [GAIN_W-1:0]   green_gain_ff;
   logic [GAIN_W-1:0]   blue_gain_ff;
   logic [DIM_W-1:0]    image_width_ff;
   logic [DIM_W-1:0]    image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         black_level_ff  <= BLACK_LEVEL_RESET;
         red_gain_ff     <= RED_GAIN_RESET;
         green_gain_ff   <= GREEN_GAIN_RESET;
         blue_gain_ff    <= BLUE_GAIN_RESET;
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_we) begin
         // drop writes to indexes beyond the register list
         case (csr_index)
            CSR_BLACK_LEVEL:  black_level_ff  <= csr_wdata[SAMPLE_W-1:0];
            CSR_RED_GAIN:     red_gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_GREEN_GAIN:   green_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_BLUE_GAIN:    blue_gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // the pipe never holds off a word
   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // ------------------------------------------ valid bits, cleared by reset
   logic [4:0] valid_ff;
   logic [4:0] valid_in;

   assign valid_in = {valid_ff[3:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // coordinates are mirrored in stage 1 and then ride along with the word
   logic [COORD_W-1:0] col_ff  [4];
   logic [COORD_W-1:0] row_ff  [4];
   logic [CROW_W-1:0]  crow_ff [4];
   logic [COORD_W-1:0] col_in;
   logic [COORD_W-1:0] row_in;
   logic [CROW_W-1:0]  crow_in;

   always_comb begin
      col_in  = image_width_ff[COORD_W-1:0] - COORD_W'(2) - req_word.quad_col;
      row_in  = image_height_ff[COORD_W-1:0] - COORD_W'(2) - req_word.quad_row;
      crow_in = image_height_ff[CROW_W:1] - CROW_W'(1) - req_word.quad_row[CROW_W:1];
   end

   always_ff @(posedge clock) begin
      col_ff[0]  <= col_in;
      row_ff[0]  <= row_in;
      crow_ff[0] <= crow_in;
      for (int s = 1; s < 4; s++) begin
         col_ff[s]  <= col_ff[s-1];
         row_ff[s]  <= row_ff[s-1];
         crow_ff[s] <= crow_ff[s-1];
      end
   end

   // --------------------------------- stage 1: unpack, subtract black level
   logic [SAMPLE_W-1:0] raw     [LANES];
   logic [SAMPLE_W-1:0] s1_samp_in [LANES];
   logic [SAMPLE_W-1:0] s1_samp_ff [LANES];
   logic [1:0]          pix0;
   logic [1:0]          pix1;

   always_comb begin
      pix0 = {req_word.pair_select, 1'b0};
      pix1 = {req_word.pair_select, 1'b1};
      raw[LANE_RED]  = unpack(req_word.upper_group, pix0);
      raw[LANE_GTOP] = unpack(req_word.upper_group, pix1);
      raw[LANE_GBOT] = unpack(req_word.lower_group, pix0);
      raw[LANE_BLUE] = unpack(req_word.lower_group, pix1);
      for (int l = 0; l < LANES; l++) begin
         s1_samp_in[l] = (raw[l] > black_level_ff) ? raw[l] - black_level_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      s1_samp_ff <= s1_samp_in;
   end

   // ------------------------- stage 2: white-balance gain, shift, saturate
   logic [GAIN_W-1:0]    gain [LANES];
   logic [ProdW-1:0]     prod [LANES];
   logic [AddrW-1:0]     s2_addr_in [LANES];
   logic [AddrW-1:0]     s2_addr_ff [LANES];

   always_comb begin
      gain[LANE_RED]  = red_gain_ff;
      gain[LANE_GTOP] = green_gain_ff;
      gain[LANE_GBOT] = green_gain_ff;
      gain[LANE_BLUE] = blue_gain_ff;
      for (int l = 0; l < LANES; l++) begin
         prod[l] = ProdW'(s1_samp_ff[l]) * ProdW'(gain[l]);
         if (prod[l][ProdW-1:8] > (ProdW - 8)'(GAMMA_ENTRIES - 1)) begin
            s2_addr_in[l] = AddrW'(GAMMA_ENTRIES - 1);
         end else begin
            s2_addr_in[l] = prod[l][8 +: AddrW];
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_addr_ff <= s2_addr_in;
   end

   // ------------------------------------------------ stage 3: gamma lookup
   logic [7:0] gam [LANES];
   logic [AddrW-1:0] rom_a_addr [2];
   logic [AddrW-1:0] rom_b_addr [2];
   logic [7:0]       rom_a_data [2];
   logic [7:0]       rom_b_data [2];

   assign rom_a_addr[0] = s2_addr_ff[LANE_RED];
   assign rom_a_addr[1] = s2_addr_ff[LANE_GTOP];
   assign rom_b_addr[0] = s2_addr_ff[LANE_GBOT];
   assign rom_b_addr[1] = s2_addr_ff[LANE_BLUE];

   rq2nv_gamma_rom #(
      .ENTRIES (GAMMA_ENTRIES)
   ) u_rom_upper (
      .clock   (clock),
      .rd_addr (rom_a_addr),
      .rd_data (rom_a_data)
   );

   rq2nv_gamma_rom #(
      .ENTRIES (GAMMA_ENTRIES)
   ) u_rom_lower (
      .clock   (clock),
      .rd_addr (rom_b_addr),
      .rd_data (rom_b_data)
   );

   assign gam[LANE_RED]  = rom_a_data[0];
   assign gam[LANE_GTOP] = rom_a_data[1];
   assign gam[LANE_GBOT] = rom_b_data[0];
   assign gam[LANE_BLUE] = rom_b_data[1];

   // ----------------------------------- stage 4: green mean, luma clamp
   logic [8:0] gsum;
   logic [7:0] s4_green_in;
   logic [7:0] s4_green_ff;
   logic [7:0] s4_red_ff;
   logic [7:0] s4_blue_ff;
   logic [7:0] s4_luma_in [LANES];
   logic [7:0] s4_luma_ff [LANES];

   always_comb begin
      gsum        = 9'(gam[LANE_GTOP]) + 9'(gam[LANE_GBOT]) + 9'd1;
      s4_green_in = gsum[8:1];
      for (int l = 0; l < LANES; l++) begin
         s4_luma_in[l] = clamp_luma(gam[l]);
      end
   end

   always_ff @(posedge clock) begin
      s4_green_ff <= s4_green_in;
      s4_red_ff   <= gam[LANE_RED];
      s4_blue_ff  <= gam[LANE_BLUE];
      s4_luma_ff  <= s4_luma_in;
   end

   // ----------------------------- stage 5: BT.601 chroma into the output word
   logic [14:0]        cb_pos;
   logic [15:0]        cb_neg;
   logic [14:0]        cr_pos;
   logic [15:0]        cr_neg;
   logic signed [16:0] cb_diff;
   logic signed [16:0] cr_diff;
   rsp_word_type       rsp_in;
   rsp_word_type       rsp_ff;

   always_comb begin
      cb_pos  = 15'(15'd112 * 15'(s4_blue_ff)) + 15'd128;
      cb_neg  = 16'(16'd38 * 16'(s4_red_ff)) + 16'(16'd74 * 16'(s4_green_ff));
      cr_pos  = 15'(15'd112 * 15'(s4_red_ff)) + 15'd128;
      cr_neg  = 16'(16'd94 * 16'(s4_green_ff)) + 16'(16'd18 * 16'(s4_blue_ff));
      cb_diff = $signed({2'b00, cb_pos}) - $signed({1'b0, cb_neg});
      cr_diff = $signed({2'b00, cr_pos}) - $signed({1'b0, cr_neg});

      rsp_in.dest_col          = col_ff[3];
      rsp_in.dest_row          = row_ff[3];
      rsp_in.chroma_row        = crow_ff[3];
      rsp_in.luma_red          = s4_luma_ff[LANE_RED];
      rsp_in.luma_green_top    = s4_luma_ff[LANE_GTOP];
      rsp_in.luma_green_bottom = s4_luma_ff[LANE_GBOT];
      rsp_in.luma_blue         = s4_luma_ff[LANE_BLUE];
      rsp_in.chroma_blue       = chroma_byte(cb_diff);
      rsp_in.chroma_red        = chroma_byte(cr_diff);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = valid_ff[4];
   assign rsp_word   = rsp_ff;

endmodule

FILE: hw/rtl/rq2nv_checker.sv
// Port-level checker of the RAW10 quad to NV12 unit, bound to the top level.
`include "assert_macros.svh"

module rq2nv_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_strobe,
   input rq2nv_pkg::rsp_word_type rsp_word
);
   import rq2nv_pkg::*;

   logic luma_ok;
   logic chroma_ok;

   assign luma_ok =
      rsp_word.luma_red >= LUMA_MIN && rsp_word.luma_red <= LUMA_MAX &&
      rsp_word.luma_green_top >= LUMA_MIN && rsp_word.luma_green_top <= LUMA_MAX &&
      rsp_word.luma_green_bottom >= LUMA_MIN &&
      rsp_word.luma_green_bottom <= LUMA_MAX &&
      rsp_word.luma_blue >= LUMA_MIN && rsp_word.luma_blue <= LUMA_MAX;

   assign chroma_ok =
      rsp_word.chroma_blue >= CHROMA_MIN && rsp_word.chroma_blue <= CHROMA_MAX &&
      rsp_word.chroma_red >= CHROMA_MIN && rsp_word.chroma_red <= CHROMA_MAX;

   // every accepted quad shows its result word on rsp_strobe
   `RQ_ASSERT(a_latency, (start && !busy) |-> ##5 rsp_strobe, "result word missing")

   // no result word without an accepted quad behind it
   `RQ_ASSERT(a_no_extra, rsp_strobe |-> $past(start && !busy, 5), "result word invented")

   `RQ_ASSERT_RSP(a_luma_range, luma_ok, "luma out of range")

   `RQ_ASSERT_RSP(a_chroma_range, chroma_ok, "chroma out of range")

endmodule

bind raw10_quad_to_nv12_unit rq2nv_checker u_rq2nv_checker (.*);

FILE: tb/nv12_result_checker.sv
// Checker for the RAW10 quad to NV12 unit: predicts every result word and compares it.
module nv12_result_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  rq2nv_pkg::req_word_type             req_word,
   input  logic                                rsp_strobe,
   input  rq2nv_pkg::rsp_word_type             rsp_word,
   input  logic                                csr_we,
   input  logic [rq2nv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rq2nv_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                  mismatch_count,
   output int                                  words_checked,
   output int                                  pending_words
);
   import rq2nv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]          gamma_curve [GAMMA_ENTRIES];
   logic [SAMPLE_W-1:0] black_sh;
   logic [GAIN_W-1:0]   red_gain_sh;
   logic [GAIN_W-1:0]   green_gain_sh;
   logic [GAIN_W-1:0]   blue_gain_sh;
   logic [DIM_W-1:0]    width_sh;
   logic [DIM_W-1:0]    height_sh;
   rsp_word_type        expected_nv12_q [$];

   // entry i counts the k in 0..254 with i^5 * 510^11 >= (2k+1)^11 * 1023^5
   initial begin
      logic [191:0] lhs;
      logic [191:0] rhs;
      logic [191:0] scale_l;
      logic [191:0] scale_r;
      int           k;
      scale_l = 1;
      repeat (11) scale_l = scale_l * 510;
      scale_r = 1;
      repeat (5) scale_r = scale_r * 1023;
      k = 0;
      for (int i = 0; i < GAMMA_ENTRIES; i++) begin
         lhs = scale_l;
         repeat (5) lhs = lhs * i;
         while (k < 255) begin
            rhs = scale_r;
            repeat (11) rhs = rhs * (2 * k + 1);
            if (lhs >= rhs) begin
               k++;
            end else begin
               break;
            end
         end
         gamma_curve[i] = 8'(k);
      end
   end

   function automatic logic [SAMPLE_W-1:0] group_sample(logic [39:0] grp, int p);
      return {grp[8*p +: 8], grp[32+2*p +: 2]};
   endfunction

   function automatic logic [7:0] develop_sample(logic [SAMPLE_W-1:0] raw,
                                                 logic [GAIN_W-1:0] gain);
      logic [SAMPLE_W-1:0] above;
      logic [21:0]         prod;
      logic [13:0]         scaled;
      above  = (raw > black_sh) ? raw - black_sh : '0;
      prod   = above * gain;
      scaled = prod[21:8];
      if (scaled > 14'd1023) scaled = 14'd1023;
      return gamma_curve[scaled[9:0]];
   endfunction

   function automatic logic [7:0] clamp_luma(logic [7:0] v);
      return (v < LUMA_MIN) ? LUMA_MIN : ((v > LUMA_MAX) ? LUMA_MAX : v);
   endfunction

   // floor shift of the signed weighted sum, offset and clamp
   function automatic logic [7:0] chroma_value(int weighted);
      int c;
      c = (weighted >>> 8) + 128;
      if (c < int'(CHROMA_MIN)) c = int'(CHROMA_MIN);
      if (c > int'(CHROMA_MAX)) c = int'(CHROMA_MAX);
      return 8'(c);
   endfunction

   function automatic rsp_word_type predict_nv12(req_word_type q);
      rsp_word_type w;
      int           base;
      int           r;
      int           gt;
      int           gb;
      int           b;
      int           g;
      base = q.pair_select ? 2 : 0;
      r  = develop_sample(group_sample(q.upper_group, base), red_gain_sh);
      gt = develop_sample(group_sample(q.upper_group, base + 1), green_gain_sh);
      gb = develop_sample(group_sample(q.lower_group, base), green_gain_sh);
      b  = develop_sample(group_sample(q.lower_group, base + 1), blue_gain_sh);
      g  = (gt + gb + 1) >> 1;
      w.dest_col          = COORD_W'(int'(width_sh) - 2 - int'(q.quad_col));
      w.dest_row          = COORD_W'(int'(height_sh) - 2 - int'(q.quad_row));
      w.chroma_row        = CROW_W'(int'(height_sh >> 1) - 1 - int'(q.quad_row >> 1));
      w.luma_red          = clamp_luma(8'(r));
      w.luma_green_top    = clamp_luma(8'(gt));
      w.luma_green_bottom = clamp_luma(8'(gb));
      w.luma_blue         = clamp_luma(8'(b));
      w.chroma_blue       = chroma_value(112 * b - 38 * r - 74 * g + 128);
      w.chroma_red        = chroma_value(112 * r - 94 * g - 18 * b + 128);
      return w;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d field %s: got %0d, want %0d",
                                   words_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         black_sh      = BLACK_LEVEL_RESET;
         red_gain_sh   = RED_GAIN_RESET;
         green_gain_sh = GREEN_GAIN_RESET;
         blue_gain_sh  = BLUE_GAIN_RESET;
         width_sh      = IMAGE_WIDTH_RESET;
         height_sh     = IMAGE_HEIGHT_RESET;
         expected_nv12_q.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (expected_nv12_q.size() == 0) begin
               report_mismatch("result word with no quad outstanding");
            end else begin
               want = expected_nv12_q.pop_front();
               check_field("dest_col", rsp_word.dest_col, want.dest_col);
               check_field("dest_row", rsp_word.dest_row, want.dest_row);
               check_field("chroma_row", rsp_word.chroma_row, want.chroma_row);
               check_field("luma_red", rsp_word.luma_red, want.luma_red);
               check_field("luma_green_top", rsp_word.luma_green_top,
                           want.luma_green_top);
               check_field("luma_green_bottom", rsp_word.luma_green_bottom,
                           want.luma_green_bottom);
               check_field("luma_blue", rsp_word.luma_blue, want.luma_blue);
               check_field("chroma_blue", rsp_word.chroma_blue, want.chroma_blue);
               check_field("chroma_red", rsp_word.chroma_red, want.chroma_red);
               words_checked++;
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            expected_nv12_q = {expected_nv12_q, predict_nv12(req_word)};
         // registers take the written value masked to their width
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_BLACK_LEVEL:  black_sh      = csr_wdata[SAMPLE_W-1:0];
               CSR_RED_GAIN:     red_gain_sh   = csr_wdata[GAIN_W-1:0];
               CSR_GREEN_GAIN:   green_gain_sh = csr_wdata[GAIN_W-1:0];
               CSR_BLUE_GAIN:    blue_gain_sh  = csr_wdata[GAIN_W-1:0];
               CSR_IMAGE_WIDTH:  width_sh      = csr_wdata[DIM_W-1:0];
               CSR_IMAGE_HEIGHT: height_sh     = csr_wdata[DIM_W-1:0];
               default: ;
            endcase
         end
      end
      pending_words = expected_nv12_q.size();
   end

endmodule

FILE: tb/raw10_quad_to_nv12_unit_tb.sv
// Testbench top of the RAW10 quad to NV12 unit: quad stimulus, register settings, verdict.
module raw10_quad_to_nv12_unit_tb;

   import rq2nv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASES          = 10;
   localparam int QUADS_PER_PHASE = 103;
   localparam int DRAIN_CYCLES    = 12;

   // indexes past the last register; writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_word_type           req_word;
   logic                   rsp_strobe;
   rsp_word_type           rsp_word;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatch_count;
   int words_checked;
   int pending_words;
   int cycle_count;
   int quads_sent;
   int settings_made;

   // stimulus-side copy of the current setting, used to aim samples and coordinates
   logic [SAMPLE_W-1:0] cur_black;
   logic [DIM_W-1:0]    cur_width;
   logic [DIM_W-1:0]    cur_height;
   bit                  steady;

   raw10_quad_to_nv12_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   nv12_result_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_checked  (words_checked),
      .pending_words  (pending_words)
   );

   always #5 clock = ~clock;

   // Bound the run; a dropped result word would otherwise hang the drain loop.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still outstanding",
                  cycle_count, pending_words);
         $display("raw10_quad_to_nv12_unit: mismatch");
         $finish;
      end
   end

   // Pack four 10-bit samples into one RAW10 group: high bytes first, low bits in byte 4.
   function automatic logic [39:0] pack_group(logic [9:0] s0, logic [9:0] s1,
                                              logic [9:0] s2, logic [9:0] s3);
      return {s3[1:0], s2[1:0], s1[1:0], s0[1:0], s3[9:2], s2[9:2], s1[9:2], s0[9:2]};
   endfunction

   function automatic req_word_type make_quad(logic [39:0] up, logic [39:0] dn,
                                              logic ps, logic [11:0] qc, logic [11:0] qr);
      req_word_type w;
      w.upper_group = up;
      w.lower_group = dn;
      w.pair_select = ps;
      w.quad_col    = qc;
      w.quad_row    = qr;
      return w;
   endfunction

   // Sample within a few codes of the black level, so the floor at zero toggles.
   function automatic logic [9:0] near_black();
      int s;
      s = int'(cur_black) + $urandom_range(0, 16) - 8;
      if (s < 0) s = 0;
      if (s > 1023) s = 1023;
      return 10'(s);
   endfunction

   // Hold start low for random gaps unless steady, then present the word and
   // advance once the accepting edge has passed.
   task automatic send_quad(input req_word_type w);
      while (!steady && $urandom_range(0, 99) < 17) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      quads_sent++;
   endtask

   // Drop start and wait until every result word has been seen.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_words != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] bl, rg, gg, bg, wd, ht);
      write_reg(CSR_BLACK_LEVEL, bl);
      write_reg(CSR_RED_GAIN, rg);
      write_reg(CSR_GREEN_GAIN, gg);
      write_reg(CSR_BLUE_GAIN, bg);
      write_reg(CSR_IMAGE_WIDTH, wd);
      write_reg(CSR_IMAGE_HEIGHT, ht);
      csr_we     <= 1'b0;
      cur_black  = bl[SAMPLE_W-1:0];
      cur_width  = wd;
      cur_height = ht;
      settings_made++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_gain();
      // half the time near unity and typical white balance, otherwise anything
      if ($urandom_range(0, 1))
         return {1'($urandom), 12'($urandom_range(200, 700))};
      return 13'($urandom);
   endfunction

   task automatic random_quad();
      logic [39:0] up;
      logic [39:0] dn;
      logic [11:0] qc;
      logic [11:0] qr;
      if ($urandom_range(0, 99) < 70) begin
         up = {8'($urandom), 32'($urandom)};
         dn = {8'($urandom), 32'($urandom)};
      end else begin
         up = pack_group(near_black(), near_black(), near_black(), near_black());
         dn = pack_group(near_black(), near_black(), near_black(), near_black());
      end
      // mostly well-placed even coordinates; the rest anywhere, odd or off the frame
      if ($urandom_range(0, 99) < 85) begin
         qc = 12'(2 * $urandom_range(0, int'(cur_width) / 2 - 1));
         qr = 12'(2 * $urandom_range(0, int'(cur_height) / 2 - 1));
      end else begin
         qc = 12'($urandom);
         qr = 12'($urandom);
      end
      send_quad(make_quad(up, dn, 1'($urandom), qc, qr));
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_word    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      cycle_count = 0;
      quads_sent  = 0;
      steady      = 1'b0;
      cur_black   = BLACK_LEVEL_RESET;
      cur_width   = IMAGE_WIDTH_RESET;
      cur_height  = IMAGE_HEIGHT_RESET;
      settings_made = 1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset setting.
      // zero and all-ones groups, both pair selects, coordinate extremes
      send_quad(make_quad('0, '0, 1'b0, 12'd0, 12'd0));
      send_quad(make_quad('1, '1, 1'b1, 12'd4094, 12'd4094));
      send_quad(make_quad('1, '0, 1'b0, 12'd4095, 12'd4095));
      // mirror lands on zero, then wraps just past the frame edge
      send_quad(make_quad('0, '1, 1'b1, 12'd1638, 12'd1230));
      send_quad(make_quad('0, '0, 1'b0, 12'd1640, 12'd1232));
      // odd coordinates are used as given
      send_quad(make_quad('0, '0, 1'b1, 12'd1, 12'd1));
      // black level exactly, one above, one below
      send_quad(make_quad(pack_group(10'd64, 10'd64, 10'd64, 10'd64),
                          pack_group(10'd64, 10'd64, 10'd64, 10'd64), 1'b0, 12'd2, 12'd2));
      send_quad(make_quad(pack_group(10'd65, 10'd65, 10'd65, 10'd65),
                          pack_group(10'd65, 10'd65, 10'd65, 10'd65), 1'b1, 12'd4, 12'd4));
      send_quad(make_quad(pack_group(10'd63, 10'd63, 10'd63, 10'd63),
                          pack_group(10'd63, 10'd63, 10'd63, 10'd63), 1'b0, 12'd6, 12'd6));
      // full-scale samples saturate after the red and blue gains
      send_quad(make_quad(pack_group(10'd1023, 10'd1023, 10'd1023, 10'd1023),
                          pack_group(10'd1023, 10'd1023, 10'd1023, 10'd1023),
                          1'b1, 12'd100, 12'd200));
      // distinct samples per pixel position, so a wrong pair pick shows
      send_quad(make_quad(pack_group(10'd100, 10'd300, 10'd600, 10'd900),
                          pack_group(10'd200, 10'd400, 10'd700, 10'd1000),
                          1'b0, 12'd10, 12'd20));
      send_quad(make_quad(pack_group(10'd100, 10'd300, 10'd600, 10'd900),
                          pack_group(10'd200, 10'd400, 10'd700, 10'd1000),
                          1'b1, 12'd10, 12'd20));
      // pure red drives Cr to its top clamp; pure blue does the same to Cb
      send_quad(make_quad(pack_group(10'd1023, 10'd0, 10'd1023, 10'd0),
                          '0, 1'b0, 12'd30, 12'd40));
      send_quad(make_quad('0, pack_group(10'd0, 10'd1023, 10'd0, 10'd1023),
                          1'b1, 12'd30, 12'd40));
      // pure green pulls both chroma bytes well below mid-scale, short of the bottom clamp
      send_quad(make_quad(pack_group(10'd0, 10'd1023, 10'd0, 10'd1023),
                          pack_group(10'd1023, 10'd0, 10'd1023, 10'd0),
                          1'b0, 12'd50, 12'd60));
      // mid gray and unequal greens, so the rounded mean matters
      send_quad(make_quad(pack_group(10'd400, 10'd401, 10'd400, 10'd401),
                          pack_group(10'd402, 10'd400, 10'd402, 10'd400),
                          1'b1, 12'd70, 12'd80));

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         steady = (ph == 3 || ph == 4);
         case (ph)
            0: program_regs(13'd0, 13'd0, 13'd0, 13'd0, 13'd2, 13'd2);
            1: program_regs(13'd1023, 13'd4095, 13'd4095, 13'd4095, 13'd4096, 13'd4096);
            2: program_regs(13'd0, 13'd256, 13'd256, 13'd256, 13'd4096, 13'd2);
            3: program_regs(13'd0, 13'd4095, 13'd4095, 13'd4095,
                            13'($urandom_range(2, 4096)), 13'($urandom_range(2, 4096)));
            default: begin
               if (ph == 5) begin
                  // writes beyond the register file must leave every setting alone
                  write_reg(CSR_SPARE_LO, 13'($urandom));
                  write_reg(CSR_SPARE_HI, 13'($urandom));
               end
               program_regs({3'($urandom), 10'($urandom_range(0, 200))},
                            random_gain(), random_gain(), random_gain(),
                            13'($urandom_range(2, 4096)), 13'($urandom_range(2, 4096)));
            end
         endcase
         repeat (QUADS_PER_PHASE) random_quad();
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d quad words under %0d register settings, checked %0d result words",
               quads_sent, settings_made, words_checked);
      $display("%0d mismatches, %0d words left unanswered", mismatch_count, pending_words);
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("raw10_quad_to_nv12_unit: match");
      end else begin
         $display("raw10_quad_to_nv12_unit: mismatch");
      end
      $finish;
   end

endmodule
